### rtl/fsvq_pkg.sv
`timescale 1ns / 1ps
package fsvq_pkg;

  // command codes carried in the input tuser
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_TRAIN = 2'd1,
    CMD_QUANT = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // configuration register indexes
  localparam logic [1:0] REG_DIMS    = 2'd0;
  localparam logic [1:0] REG_CENTERS = 2'd1;
  localparam logic [1:0] REG_LEARN   = 2'd2;

  localparam int SEL_W   = 4;
  localparam int POS_W   = 4;
  localparam int IN_W    = 16;
  localparam int CFG_W   = 16;
  localparam int LR_W    = 16;
  localparam int DIST_W  = 36;
  localparam int COUNT_W = 32;
  localparam int OUT_W   = 72;

  localparam logic [DIST_W-1:0]  DIST_MAX  = {DIST_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // score unit: 16-bit digits of an 80-bit operand against a 36-bit one
  localparam int DIGIT_W = 16;
  localparam int OPA_W   = 80;
  localparam int PROD_W  = 112;
  localparam int SCORE_W = 104;

  // one classified word between front and back
  typedef struct packed {
    cmd_e                   cmd;
    logic [SEL_W-1:0]       sel;
    logic [POS_W-1:0]       pos;
    logic signed [IN_W-1:0] value;
    logic                   last;
  } item_t;

endpackage

### rtl/frequency_sensitive_vq_learner_core.sv
`timescale 1ns / 1ps
// a final quantize or train word runs a distance sweep over the codebook ram; a train word
// also runs the 16-bit digit score multiplier and an update sweep of the winning center
// reset: queue and output empty, win counts all one, registers at defaults;
// codebook and sample buffer hold no defined value until written
module frequency_sensitive_vq_learner_core #(
  parameter int CENTERS    = 16,
  parameter int DIM        = 16,
  parameter int VALUE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // center_select, element_position, element_value
  input  logic [1:0]  s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // winner, winner_distance, winner_count
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import fsvq_pkg::*;

  localparam int DCW = $clog2(DIM + 1);
  localparam int CCW = $clog2(CENTERS + 1);

  logic [4:0]      dims_q, cens_q;
  logic [LR_W-1:0] lr_q;
  logic [DCW-1:0]  dims_eff;
  logic [CCW-1:0]  cens_eff;
  logic            q_valid, q_ready;
  item_t           q_item;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= 5'd16;
      cens_q <= 5'd16;
      lr_q   <= 16'd13107;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DIMS:    dims_q <= cfg_data_i[4:0];
        REG_CENTERS: cens_q <= cfg_data_i[4:0];
        REG_LEARN:   lr_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp sizes into the built range
  always_comb begin
    if (dims_q == 5'd0) dims_eff = DCW'(1);
    else if (32'(dims_q) > DIM) dims_eff = DCW'(DIM);
    else dims_eff = DCW'(dims_q);
    if (cens_q == 5'd0) cens_eff = CCW'(1);
    else if (32'(cens_q) > CENTERS) cens_eff = CCW'(CENTERS);
    else cens_eff = CCW'(cens_q);
  end

  fsvq_front #(.DIM(DIM), .DCW(DCW)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .dims_eff_i    (dims_eff),
    .q_valid_o     (q_valid),
    .q_ready_i     (q_ready),
    .q_item_o      (q_item)
  );

  fsvq_back #(
    .CENTERS(CENTERS), .DIM(DIM), .VALUE_BITS(VALUE_BITS), .DCW(DCW), .CCW(CCW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_ready_o     (q_ready),
    .q_item_i      (q_item),
    .dims_eff_i    (dims_eff),
    .cens_eff_i    (cens_eff),
    .learn_rate_i  (lr_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

`ifndef SYNTHESIS
  // a word with a real command always lands in the queue
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser != CMD_NONE)) |=> q_valid)
    else $error("accepted word missing from queue");

  // win counts start at one and saturate, so a reported count is never zero
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[71:40] != 32'd0))
    else $error("reported win count is zero");
`endif

endmodule

### rtl/fsvq_ram.sv
`timescale 1ns / 1ps
module fsvq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/fsvq_front.sv
`timescale 1ns / 1ps
module fsvq_front #(
  parameter int DIM = 16,
  parameter int DCW = $clog2(DIM + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [23:0]            s_axis_tdata,  // center_select, element_position, element_value
  input  logic [1:0]             s_axis_tuser,  // command
  input  logic [DCW-1:0]         dims_eff_i,
  output logic                   q_valid_o,
  input  logic                   q_ready_i,
  output fsvq_pkg::item_t        q_item_o
);
  import fsvq_pkg::*;

  item_t      slot_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  item_t      item;

  // classify the incoming word
  always_comb begin
    item.cmd   = cmd_e'(s_axis_tuser);
    item.sel   = s_axis_tdata[3:0];
    item.pos   = s_axis_tdata[7:4];
    item.value = $signed(s_axis_tdata[23:8]);
    item.last  = (32'(item.pos) + 32'd1) == 32'(dims_eff_i);
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  // unused command code is consumed and dropped here
  assign push = s_axis_tvalid && s_axis_tready && (item.cmd != CMD_NONE);
  assign pop  = q_valid_o && q_ready_i;

  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = slot_q[rd_q];

  // two-entry queue pointers
  always_comb begin
    wr_d  = wr_q ^ push;
    rd_d  = rd_q ^ pop;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= item;
    end
  end

endmodule

### rtl/fsvq_back.sv
`timescale 1ns / 1ps
module fsvq_back #(
  parameter int CENTERS    = 16,
  parameter int DIM        = 16,
  parameter int VALUE_BITS = 16,
  parameter int DCW        = $clog2(DIM + 1),
  parameter int CCW        = $clog2(CENTERS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  output logic                          q_ready_o,
  input  fsvq_pkg::item_t               q_item_i,
  input  logic [DCW-1:0]                dims_eff_i,
  input  logic [CCW-1:0]                cens_eff_i,
  input  logic [fsvq_pkg::LR_W-1:0]     learn_rate_i,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [fsvq_pkg::OUT_W-1:0]    m_axis_tdata  // winner, winner_distance, winner_count
);
  import fsvq_pkg::*;

  localparam int VB   = VALUE_BITS;
  localparam int CIW  = (CENTERS > 1) ? $clog2(CENTERS) : 1;
  localparam int PW   = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int AW   = (CENTERS * DIM > 1) ? $clog2(CENTERS * DIM) : 1;
  localparam int DW1  = VB + 1;
  localparam int MBW  = (DW1 > LR_W + 1) ? DW1 : LR_W + 1;
  localparam int MPW  = DW1 + MBW;
  localparam int SUMW = ((MPW > DIST_W) ? MPW : DIST_W) + 1;
  localparam longint VMAX = (64'sd1 <<< (VB - 1)) - 64'sd1;
  localparam longint VMIN = -VMAX - 64'sd1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIST  = 6'b000010,
    ST_SCORE = 6'b000100,
    ST_NEXT  = 6'b001000,
    ST_UPD   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  function automatic logic signed [VB-1:0] sat_in(logic signed [IN_W-1:0] v);
    longint w;
    w = longint'(v);
    if (w > VMAX) w = VMAX;
    else if (w < VMIN) w = VMIN;
    return VB'(w);
  endfunction

  state_e                 st_q, st_d;
  logic                   train_q, train_d;
  logic [CIW-1:0]         m_q, m_d, win_q, win_d;
  logic [DCW-1:0]         iss_q, iss_d;
  logic [DIST_W-1:0]      acc_q, acc_d, dist_q, dist_d, wdist_q, wdist_d;
  logic [SCORE_W-1:0]     score_q, score_d, best_q, best_d;
  logic [OPA_W-1:0]       a_q, a_d;
  logic [DIST_W-1:0]      b_q, b_d;
  logic [PROD_W-1:0]      prod_q, prod_d;
  logic [2:0]             k_q, k_d;
  logic                   pass_q, pass_d;
  logic                   ov_q, ov_d;
  logic [OUT_W-1:0]       od_q, od_d;

  logic signed [VB-1:0]   samp_q [DIM];
  logic [COUNT_W-1:0]     cnt_q [CENTERS];

  // read pipeline registers
  logic                   v1_q, v1_d, last1_q, last1_d, v2_q, v2_d, last2_q, last2_d;
  logic [PW-1:0]          idx1_q, idx1_d, idx2_q, idx2_d;
  logic signed [VB-1:0]   x1_q, x1_d, c2_q, c2_d;
  logic signed [MPW-1:0]  p2_q, p2_d;

  logic                   issue;
  logic [CIW-1:0]         base;
  logic [AW-1:0]          raddr, waddr;
  logic                   we;
  logic [VB-1:0]          wdata, rdata;
  logic signed [DW1-1:0]  diff;
  logic signed [MBW-1:0]  mb;
  logic [SUMW-1:0]        sum_w;
  logic [DIST_W-1:0]      sum_sat;
  logic signed [VB+1:0]   newc;
  logic signed [VB-1:0]   newc_sat;
  logic [COUNT_W-1:0]     cnt_rd;
  logic [CIW-1:0]         cnt_idx;
  logic [DIGIT_W+DIST_W-1:0] partial;
  logic                   pop, load_ok, better, last_center;
  logic                   cnt_load, cnt_inc;

  fsvq_ram #(.WIDTH(VB), .DEPTH(CENTERS * DIM), .AW(AW)) u_codebook (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign q_ready_o = (st_q == ST_IDLE);
  assign pop       = q_valid_i && q_ready_o;
  assign load_ok   = (32'(q_item_i.sel) < CENTERS) && (32'(q_item_i.pos) < DIM);

  // element read issue for distance and update sweeps
  assign issue = ((st_q == ST_DIST) || (st_q == ST_UPD)) && (iss_q < dims_eff_i);
  assign base  = (st_q == ST_UPD) ? win_q : m_q;
  assign raddr = AW'(32'(base) * DIM + 32'(iss_q));

  // stage two: shared multiplier, diff squared or rate times diff
  assign diff = DW1'(x1_q) - DW1'($signed(rdata));
  assign mb   = (st_q == ST_UPD) ? $signed(MBW'({1'b0, learn_rate_i})) : MBW'(diff);

  // stage three: saturating accumulate
  assign sum_w   = SUMW'(acc_q) + SUMW'($unsigned(p2_q));
  assign sum_sat = (sum_w > SUMW'(DIST_MAX)) ? DIST_MAX : DIST_W'(sum_w);

  // stage three: center step with floor shift and clamp
  always_comb begin
    newc = (VB + 2)'(c2_q) + (VB + 2)'(p2_q >>> 16);
    if (longint'(newc) > VMAX) newc_sat = VB'(VMAX);
    else if (longint'(newc) < VMIN) newc_sat = VB'(VMIN);
    else newc_sat = VB'(newc);
  end

  // codebook write: loads when idle, updates during the sweep
  always_comb begin
    if (st_q == ST_UPD) begin
      we    = v2_q;
      waddr = AW'(32'(win_q) * DIM + 32'(idx2_q));
      wdata = newc_sat;
    end else begin
      we    = pop && (q_item_i.cmd == CMD_LOAD) && load_ok;
      waddr = AW'(32'(q_item_i.sel) * DIM + 32'(q_item_i.pos));
      wdata = sat_in(q_item_i.value);
    end
  end

  assign cnt_idx = (st_q == ST_SCORE) ? m_q : win_q;
  assign cnt_rd  = cnt_q[cnt_idx];
  assign partial = a_q[OPA_W-1 -: DIGIT_W] * b_q;

  assign better      = (m_q == '0) || (train_q ? (score_q < best_q) : (dist_q < wdist_q));
  assign last_center = (32'(m_q) + 32'd1) >= 32'(cens_eff_i);

  // pipeline stages
  always_comb begin
    v1_d    = issue;
    last1_d = (32'(iss_q) + 32'd1) == 32'(dims_eff_i);
    idx1_d  = PW'(iss_q);
    x1_d    = samp_q[PW'(iss_q)];
    v2_d    = v1_q;
    last2_d = last1_q;
    idx2_d  = idx1_q;
    c2_d    = $signed(rdata);
    p2_d    = diff * mb;
  end

  // sequencer
  always_comb begin
    st_d    = st_q;
    train_d = train_q;
    m_d     = m_q;
    win_d   = win_q;
    iss_d   = issue ? iss_q + DCW'(1) : iss_q;
    acc_d   = acc_q;
    dist_d  = dist_q;
    wdist_d = wdist_q;
    score_d = score_q;
    best_d  = best_q;
    a_d     = a_q;
    b_d     = b_q;
    prod_d  = prod_q;
    k_d     = k_q;
    pass_d  = pass_q;
    ov_d    = ov_q && !m_axis_tready;
    od_d    = od_q;
    cnt_inc = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (pop && (q_item_i.cmd != CMD_LOAD) && q_item_i.last) begin
          train_d = (q_item_i.cmd == CMD_TRAIN);
          m_d     = '0;
          iss_d   = '0;
          acc_d   = '0;
          st_d    = ST_DIST;
        end
      end
      ST_DIST: begin
        if (v2_q) begin
          acc_d = sum_sat;
          if (last2_q) begin
            acc_d  = '0;
            dist_d = sum_sat;
            a_d    = {12'b0, sum_sat, 32'b0};
            b_d    = sum_sat;
            prod_d = '0;
            k_d    = 3'd3;
            pass_d = 1'b0;
            st_d   = train_q ? ST_SCORE : ST_NEXT;
          end
        end
      end
      ST_SCORE: begin
        // one digit per cycle: d*d, then (d*d)*count
        prod_d = (prod_q << DIGIT_W) + PROD_W'(partial);
        a_d    = a_q << DIGIT_W;
        k_d    = k_q - 3'd1;
        if (k_q == 3'd1) begin
          if (!pass_q) begin
            a_d    = prod_d[OPA_W-1:0];
            b_d    = DIST_W'(cnt_rd);
            prod_d = '0;
            k_d    = 3'd5;
            pass_d = 1'b1;
          end else begin
            score_d = prod_d[SCORE_W-1:0];
            st_d    = ST_NEXT;
          end
        end
      end
      ST_NEXT: begin
        if (better) begin
          win_d   = m_q;
          wdist_d = dist_q;
          best_d  = score_q;
        end
        iss_d = '0;
        if (last_center) begin
          st_d = train_q ? ST_UPD : ST_OUT;
        end else begin
          m_d  = m_q + CIW'(1);
          st_d = ST_DIST;
        end
      end
      ST_UPD: begin
        if (v2_q && last2_q) begin
          cnt_inc = 1'b1;
          st_d    = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ov_q || m_axis_tready) begin
          ov_d = 1'b1;
          od_d = {cnt_rd, wdist_q, SEL_W'(win_q)};
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  assign cnt_load = pop && (q_item_i.cmd == CMD_LOAD) && load_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      ov_q    <= 1'b0;
      win_q   <= '0;
      wdist_q <= '0;
      for (int c = 0; c < CENTERS; c++) begin
        cnt_q[c] <= COUNT_W'(1);
      end
    end else begin
      st_q    <= st_d;
      v1_q    <= v1_d;
      v2_q    <= v2_d;
      ov_q    <= ov_d;
      win_q   <= win_d;
      wdist_q <= wdist_d;
      // win counts: reset to one on load, saturating increment on a training win
      if (cnt_load) begin
        cnt_q[CIW'(q_item_i.sel)] <= COUNT_W'(1);
      end else if (cnt_inc && (cnt_q[win_q] != COUNT_MAX)) begin
        cnt_q[win_q] <= cnt_q[win_q] + COUNT_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    train_q <= train_d;
    m_q     <= m_d;
    iss_q   <= iss_d;
    acc_q   <= acc_d;
    dist_q  <= dist_d;
    score_q <= score_d;
    best_q  <= best_d;
    a_q     <= a_d;
    b_q     <= b_d;
    prod_q  <= prod_d;
    k_q     <= k_d;
    pass_q  <= pass_d;
    od_q    <= od_d;
    last1_q <= last1_d;
    last2_q <= last2_d;
    idx1_q  <= idx1_d;
    idx2_q  <= idx2_d;
    x1_q    <= x1_d;
    c2_q    <= c2_d;
    p2_q    <= p2_d;
    if (pop && (q_item_i.cmd != CMD_LOAD) && (32'(q_item_i.pos) < DIM)) begin
      samp_q[PW'(q_item_i.pos)] <= sat_in(q_item_i.value);
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;

endmodule

### verif/frequency_sensitive_vq_learner_core_tb.sv
`timescale 1ns / 1ps
module frequency_sensitive_vq_learner_core_tb;
  import fsvq_pkg::*;

  localparam int NC = 16;
  localparam int ND = 16;
  localparam longint CYCLE_LIMIT = 4000000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  frequency_sensitive_vq_learner_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  typedef struct packed {
    logic [1:0]  cmd;
    logic [23:0] data;
  } word_t;

  // predictor state
  logic signed [15:0] book [NC][ND];
  logic [31:0]        wins [NC];
  logic signed [15:0] samp [ND];
  int unsigned        dims_cfg, cens_cfg, rate_cfg;

  word_t       word_q [$];
  logic [71:0] winner_q [$];
  int          errors;
  longint      cycles;
  int          tx_gap, rx_gap;
  bit          stim_done;

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [35:0] dist_to(int m, int d);
    logic [36:0] acc;
    longint      diff;
    acc = 0;
    for (int i = 0; i < d; i++) begin
      diff = longint'(samp[i]) - longint'(book[m][i]);
      acc = acc + 37'(diff * diff);
      if (acc > 37'(DIST_MAX)) acc = 37'(DIST_MAX);
    end
    return acc[35:0];
  endfunction

  // applies one word to the model; pushes the expected result if any
  function automatic void predict_word(word_t w);
    logic [3:0]         sel, pos;
    logic signed [15:0] val;
    int                 d, c, win;
    logic [35:0]        wd, dd;
    logic [143:0]       bs, cs;
    longint             cv, p, sh;
    sel = w.data[3:0];
    pos = w.data[7:4];
    val = w.data[23:8];
    if (w.cmd == CMD_LOAD) begin
      book[sel][pos] = val;
      wins[sel] = 1;
      return;
    end
    if (w.cmd == CMD_NONE) return;
    samp[pos] = val;
    d = (dims_cfg < 1) ? 1 : (dims_cfg > ND) ? ND : dims_cfg;
    c = (cens_cfg < 1) ? 1 : (cens_cfg > NC) ? NC : cens_cfg;
    if (pos != d - 1) return;
    win = 0;
    wd = dist_to(0, d);
    if (w.cmd == CMD_TRAIN) begin
      bs = 144'(wd) * 144'(wd) * 144'(wins[0]);
      for (int m = 1; m < c; m++) begin
        dd = dist_to(m, d);
        cs = 144'(dd) * 144'(dd) * 144'(wins[m]);
        if (cs < bs) begin
          bs = cs; win = m; wd = dd;
        end
      end
      if (wins[win] != COUNT_MAX) wins[win]++;
      for (int i = 0; i < d; i++) begin
        cv = book[win][i];
        p = longint'(rate_cfg) * (longint'(samp[i]) - cv);
        sh = p >>> 16;
        book[win][i] = 16'(cv + sh);
      end
    end else begin
      for (int m = 1; m < c; m++) begin
        dd = dist_to(m, d);
        if (dd < wd) begin
          wd = dd; win = m;
        end
      end
    end
    winner_q.push_back({wins[win], wd, 4'(win)});
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      tx_gap <= 0;
    end else if (s_axis_tvalid && !s_axis_tready) begin
    end else if (tx_gap > 0) begin
      s_axis_tvalid <= 1'b0;
      tx_gap <= tx_gap - 1;
    end else if (word_q.size() > 0) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tuser <= word_q[0].cmd;
      s_axis_tdata <= word_q[0].data;
      predict_word(word_q.pop_front());
      tx_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (winner_q.size() == 0) begin
          $display("%0t unexpected result, expected none, actual %h", $time, m_axis_tdata);
          errors++;
        end else begin
          if (m_axis_tdata[3:0] !== winner_q[0][3:0]) begin
            $display("%0t winner expected %0d actual %0d", $time,
                     winner_q[0][3:0], m_axis_tdata[3:0]);
            errors++;
          end
          if (m_axis_tdata[39:4] !== winner_q[0][39:4]) begin
            $display("%0t winner_distance expected %0d actual %0d", $time,
                     winner_q[0][39:4], m_axis_tdata[39:4]);
            errors++;
          end
          if (m_axis_tdata[71:40] !== winner_q[0][71:40]) begin
            $display("%0t winner_count expected %0d actual %0d", $time,
                     winner_q[0][71:40], m_axis_tdata[71:40]);
            errors++;
          end
          void'(winner_q.pop_front());
        end
      end
      if (rx_gap > 0) begin
        m_axis_tready <= 1'b0;
        rx_gap <= rx_gap - 1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        rx_gap <= (stim_done || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("frequency_sensitive_vq_learner_core: mismatch");
      $finish;
    end
  end

  function automatic word_t mk(logic [1:0] cmd, int sel, int pos, int val);
    word_t w;
    w.cmd = cmd;
    w.data = {16'(val), 4'(pos), 4'(sel)};
    return w;
  endfunction

  function automatic int rnd_val();
    case ($urandom_range(0, 5))
      0: return 32767;
      1: return -32768;
      2: return $urandom_range(0, 65535) - 32768;
      default: return int'($urandom_range(0, 4000)) - 2000;
    endcase
  endfunction

  // waits for all results, then lets the block settle
  task automatic drain();
    wait (word_q.size() == 0);
    @(posedge clk_i);
    while (s_axis_tvalid) @(posedge clk_i);
    wait (winner_q.size() == 0);
    repeat (16 * 27 + 30) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= 16'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_DIMS) dims_cfg = val & 31;
    else if (idx == REG_CENTERS) cens_cfg = val & 31;
    else rate_cfg = val & 16'hffff;
  endtask

  // sets the registers, three random loads over the filled codebook, then one phase of samples
  task automatic run_phase(int d, int c, int rate, int nsamples);
    cmd_e cmd;
    int   de;
    de = (d < 1) ? 1 : (d > ND) ? ND : d;
    write_reg(REG_DIMS, d);
    write_reg(REG_CENTERS, c);
    write_reg(REG_LEARN, rate);
    for (int k = 0; k < 3; k++)
      word_q.push_back(mk(CMD_LOAD, $urandom_range(0, 15), $urandom_range(0, 15),
                          rnd_val()));
    for (int s = 0; s < nsamples; s++) begin
      cmd = ($urandom_range(0, 3) == 0) ? CMD_QUANT : CMD_TRAIN;
      if ($urandom_range(0, 15) == 0)
        word_q.push_back(mk(CMD_NONE, $urandom_range(0, 15), $urandom_range(0, 15),
                            rnd_val()));
      if ($urandom_range(0, 9) == 0)
        word_q.push_back(mk(CMD_LOAD, $urandom_range(0, 15), $urandom_range(0, 15),
                            rnd_val()));
      for (int i = 0; i < de; i++)
        word_q.push_back(mk(cmd, $urandom_range(0, 15), i, rnd_val()));
    end
    drain();
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    stim_done = 0;
    rx_gap = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    dims_cfg = 16; cens_cfg = 16; rate_cfg = 13107;
    for (int m = 0; m < NC; m++) wins[m] = 1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: defaults, extreme values, ties, both commands
    for (int m = 0; m < NC; m++)
      for (int i = 0; i < ND; i++)
        word_q.push_back(mk(CMD_LOAD, m, i, (m < 2) ? 0 : -32768));
    for (int i = 0; i < ND; i++) word_q.push_back(mk(CMD_QUANT, 15, i, 32767));
    for (int i = 0; i < ND; i++) word_q.push_back(mk(CMD_TRAIN, 0, i, 0));
    word_q.push_back(mk(CMD_NONE, 15, 15, -1));
    drain();

    // register extremes, including out of range values
    run_phase(1, 1, 65535, 8);
    run_phase(0, 0, 0, 8);
    run_phase(31, 31, 1, 1);
    run_phase(2, 16, 65535, 15);
    run_phase(3, 8, 13107, 10);
    run_phase(1, 16, 40000, 15);
    run_phase(4, 5, 32768, 5);
    run_phase(16, 16, 13107, 1);
    stim_done = 1;
    drain();
    if (errors == 0) begin
      $display("frequency_sensitive_vq_learner_core: match");
    end else begin
      $display("frequency_sensitive_vq_learner_core: mismatch");
    end
    $finish;
  end

endmodule

### frequency_sensitive_vq_learner_core.f
rtl/fsvq_pkg.sv
rtl/fsvq_ram.sv
rtl/fsvq_front.sv
rtl/fsvq_back.sv
rtl/frequency_sensitive_vq_learner_core.sv
verif/frequency_sensitive_vq_learner_core_tb.sv
